// ===== rtl/core/scfl_pkg.sv =====
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants of the size class free list selector.
// ----------------------------------------------------------------------------
package scfl_pkg;

    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned CLS_W    = 6;

    // largest block size that still has a class of its own
    localparam logic [SIZE_W-1:0] MAX_BLOCK = 32'd2097152;

    // size class boundaries
    localparam logic [SIZE_W-1:0] SIZE_TINY  = 32'd16;
    localparam logic [SIZE_W-1:0] SIZE_SMALL = 32'd24;
    localparam logic [SIZE_W-1:0] SIZE_STEP  = 32'd1024;

    // first power class sits at 2^11, so class = 24 + msb(size - 1)
    localparam logic [CLS_W-1:0] POW_CLASS_BASE = 6'd24;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_EMPTY  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic calc;      // register ceiling and floor classes
        logic exec;      // search or update the map, load the result register
    } scfl_cmd_t;

endpackage

// ===== rtl/core/scfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// scfl_ctrl
// Controller: sequences accept, classify and execute, owns the result valid.
// ----------------------------------------------------------------------------
module scfl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output scfl_pkg::scfl_cmd_t cmd
);
    import scfl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASS,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    // result register can take a new item when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign cmd.load_in = (state_reg == ST_IDLE) && s_valid;
    assign cmd.calc    = (state_reg == ST_CLASS);
    assign cmd.exec    = (state_reg == ST_EXEC) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one being drained
            if ((state_reg == ST_EXEC) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/scfl_dp.sv =====
// ----------------------------------------------------------------------------
// scfl_dp
// Datapath: size to class mapping, non-empty map and the result register.
// ----------------------------------------------------------------------------
module scfl_dp #(
    parameter int unsigned NUM_LISTS = 46
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scfl_pkg::scfl_cmd_t           cmd,
    input  logic [scfl_pkg::TYPE_W-1:0]   in_req_type,
    input  logic [scfl_pkg::SIZE_W-1:0]   in_request_size,
    input  logic [scfl_pkg::CLS_W-1:0]    in_list_index,
    output logic [scfl_pkg::CLS_W-1:0]    out_class_index,
    output logic                          out_found,
    output logic [scfl_pkg::CLS_W-1:0]    out_start_class,
    output logic [scfl_pkg::CLS_W-1:0]    out_fallback_index,
    output logic                          out_fallback_valid
);
    import scfl_pkg::*;

    localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_LISTS - 1);

    // captured item
    logic [TYPE_W-1:0]    type_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [CLS_W-1:0]     idx_reg;

    // classify stage
    logic [CLS_W-1:0]     start_reg,  start_next;
    logic [CLS_W-1:0]     floor_reg,  floor_next;

    // state
    logic [NUM_LISTS-1:0] map_reg,    map_next;

    // result register
    logic [CLS_W-1:0]     cls_reg,    cls_next;
    logic                 found_reg,  found_next;
    logic [CLS_W-1:0]     ostart_reg;
    logic [CLS_W-1:0]     fb_idx_reg, fb_idx_next;
    logic                 fb_vld_reg, fb_vld_next;

    // ---------------- classify ----------------
    logic [SIZE_W-1:0]    size_m1;
    logic [4:0]           msb_pos;
    logic [11:0]          step_sum;
    logic [CLS_W-1:0]     c_raw;
    logic                 exact;

    assign size_m1  = size_reg - SIZE_W'(1);
    assign step_sum = {1'b0, size_reg[10:0]} + 12'd31;

    // msb of size - 1 gives the ceiling power of two
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                msb_pos = 5'(i);
            end
        end
    end

    always_comb begin
        if (size_reg <= SIZE_TINY) begin
            c_raw = '0;
            exact = 1'b1;
        end else if (size_reg <= SIZE_SMALL) begin
            c_raw = CLS_W'(1);
            exact = (size_reg == SIZE_SMALL);
        end else if (size_reg <= SIZE_STEP) begin
            c_raw = step_sum[10:5] + CLS_W'(1);
            exact = (size_reg[4:0] == 5'd0);
        end else begin
            c_raw = POW_CLASS_BASE + {1'b0, msb_pos};
            exact = ((size_reg & size_m1) == '0);
        end

        if (size_reg > MAX_BLOCK || c_raw > LAST_CLASS) begin
            start_next = LAST_CLASS;
        end else begin
            start_next = c_raw;
        end

        // floor drops one class unless exact, lowest or catch-all
        if (start_next != '0 && start_next != LAST_CLASS && !exact) begin
            floor_next = start_next - CLS_W'(1);
        end else begin
            floor_next = start_next;
        end
    end

    // ---------------- execute ----------------
    logic [NUM_LISTS-1:0] search_vec;
    logic [NUM_LISTS-1:0] set_vec;
    logic [NUM_LISTS-1:0] clr_vec;
    logic [CLS_W-1:0]     hit_idx;
    logic                 hit;

    always_comb begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            search_vec[i] = map_reg[i] && (CLS_W'(i) >= start_reg);
            set_vec[i]    = (CLS_W'(i) == floor_reg);
            clr_vec[i]    = (CLS_W'(i) == idx_reg);
        end
    end

    // lowest set bit at or above the start class
    always_comb begin
        hit_idx = '0;
        hit     = 1'b0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (search_vec[i]) begin
                hit_idx = CLS_W'(i);
                hit     = 1'b1;
            end
        end
    end

    always_comb begin
        map_next    = map_reg;
        cls_next    = '0;
        found_next  = 1'b0;
        case (type_reg)
            REQ_FIND: begin
                cls_next   = hit_idx;
                found_next = hit;
            end
            REQ_INSERT: begin
                map_next   = map_reg | set_vec;
                cls_next   = floor_reg;
                found_next = 1'b1;
            end
            REQ_EMPTY: begin
                map_next   = map_reg & ~clr_vec;
                cls_next   = idx_reg;
                found_next = 1'b1;
            end
            default: begin
                map_next = map_reg;
            end
        endcase
        fb_vld_next = (start_reg != '0);
        fb_idx_next = fb_vld_next ? start_reg - CLS_W'(1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= '0;
        end else if (cmd.exec) begin
            map_reg <= map_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            type_reg <= in_req_type;
            size_reg <= in_request_size;
            idx_reg  <= in_list_index;
        end
        if (cmd.calc) begin
            start_reg <= start_next;
            floor_reg <= floor_next;
        end
        if (cmd.exec) begin
            cls_reg    <= cls_next;
            found_reg  <= found_next;
            ostart_reg <= start_reg;
            fb_idx_reg <= fb_idx_next;
            fb_vld_reg <= fb_vld_next;
        end
    end

    assign out_class_index    = cls_reg;
    assign out_found          = found_reg;
    assign out_start_class    = ostart_reg;
    assign out_fallback_index = fb_idx_reg;
    assign out_fallback_valid = fb_vld_reg;

endmodule

// ===== rtl/core/size_class_free_list_selector_top.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_selector_top
// Maps block sizes to segregated free-list classes and keeps the non-empty map.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | req_type, request_size, list_index
//  m_      | out | m_valid / m_ready  | class_index, found, start_class,
//          |     |                    | fallback_index, fallback_valid
//
//  an item goes through accept, classify (size to class), then search or
//  update of the non-empty map into the result register
//  the next item is accepted while a result still waits on m_ready; a stalled
//  result holds the execute step, so the map is never ahead of the output
//  synchronous active-low reset clears the map and drops m_valid
// ----------------------------------------------------------------------------
module size_class_free_list_selector_top #(
    parameter int unsigned NUM_LISTS = 46
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [scfl_pkg::TYPE_W-1:0]   s_req_type,
    input  logic [scfl_pkg::SIZE_W-1:0]   s_request_size,
    input  logic [scfl_pkg::CLS_W-1:0]    s_list_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scfl_pkg::CLS_W-1:0]    m_class_index,
    output logic                          m_found,
    output logic [scfl_pkg::CLS_W-1:0]    m_start_class,
    output logic [scfl_pkg::CLS_W-1:0]    m_fallback_index,
    output logic                          m_fallback_valid
);
    import scfl_pkg::*;

    scfl_cmd_t cmd;

    scfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    scfl_dp #(
        .NUM_LISTS (NUM_LISTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .in_req_type        (s_req_type),
        .in_request_size    (s_request_size),
        .in_list_index      (s_list_index),
        .out_class_index    (m_class_index),
        .out_found          (m_found),
        .out_start_class    (m_start_class),
        .out_fallback_index (m_fallback_index),
        .out_fallback_valid (m_fallback_valid)
    );

endmodule

// ===== dv/size_class_free_list_selector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_free_list_selector_checker
// Watches both channels of the size class selector, keeps its own copy of the
// non-empty map, predicts each result in order and compares it per field.
// ----------------------------------------------------------------------------
module size_class_free_list_selector_checker #(
    parameter int unsigned NUM_LISTS = 46
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [scfl_pkg::TYPE_W-1:0]   s_req_type,
    input  logic [scfl_pkg::SIZE_W-1:0]   s_request_size,
    input  logic [scfl_pkg::CLS_W-1:0]    s_list_index,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [scfl_pkg::CLS_W-1:0]    m_class_index,
    input  logic                          m_found,
    input  logic [scfl_pkg::CLS_W-1:0]    m_start_class,
    input  logic [scfl_pkg::CLS_W-1:0]    m_fallback_index,
    input  logic                          m_fallback_valid,
    output int unsigned                   mismatch_count,
    output int unsigned                   pending_count
);

    import scfl_pkg::*;

    localparam int unsigned LAST_CLASS = NUM_LISTS - 1;
    // power classes: class c holds 2^(c - POW_OFFSET) bytes
    localparam int unsigned POW_OFFSET = 23;
    localparam int unsigned FIRST_POW  = 34;

    typedef struct packed {
        logic [CLS_W-1:0] class_index;
        logic             found;
        logic [CLS_W-1:0] start_class;
        logic [CLS_W-1:0] fallback_index;
        logic             fallback_valid;
    } class_result_t;

    logic [NUM_LISTS-1:0] nonempty_map;
    class_result_t        predicted_classes[$];
    class_result_t        want;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        nonempty_map   = '0;
    end

    function automatic int unsigned class_bytes(int unsigned cls);
        if (cls < 2)
            return 16 + 8 * cls;
        if (cls < FIRST_POW)
            return 32 * (cls - 1);
        return 32'd1 << (cls - POW_OFFSET);
    endfunction

    function automatic int unsigned ceiling_class(logic [SIZE_W-1:0] size);
        int unsigned cls;
        int unsigned k;
        if (size > MAX_BLOCK)
            return LAST_CLASS;
        if (size <= SIZE_TINY) begin
            cls = 0;
        end else if (size <= SIZE_SMALL) begin
            cls = 1;
        end else if (size <= SIZE_STEP) begin
            cls = (size + 31) / 32 + 1;
        end else begin
            // smallest power of two that holds the size
            k = 0;
            while ((64'd1 << k) < {32'd0, size})
                k++;
            cls = POW_OFFSET + k;
        end
        return (cls > LAST_CLASS) ? LAST_CLASS : cls;
    endfunction

    function automatic class_result_t classify_request(logic [TYPE_W-1:0] req,
                                                      logic [SIZE_W-1:0] size,
                                                      logic [CLS_W-1:0]  idx);
        class_result_t r;
        int unsigned   start;
        int unsigned   cls;
        bit            hit;
        start = ceiling_class(size);
        cls   = 0;
        hit   = 1'b0;
        case (req)
            REQ_FIND: begin
                for (int unsigned i = start; i < NUM_LISTS; i++) begin
                    if (!hit && nonempty_map[i]) begin
                        hit = 1'b1;
                        cls = i;
                    end
                end
            end
            REQ_INSERT: begin
                cls = start;
                if (cls != 0 && cls != LAST_CLASS && class_bytes(cls) != size)
                    cls--;
                nonempty_map[cls] = 1'b1;
                hit = 1'b1;
            end
            REQ_EMPTY: begin
                if (idx < NUM_LISTS)
                    nonempty_map[idx] = 1'b0;
                cls = idx;
                hit = 1'b1;
            end
            default: begin
                // unused code leaves the map alone
            end
        endcase
        r.class_index    = cls[CLS_W-1:0];
        r.found          = hit;
        r.start_class    = start[CLS_W-1:0];
        r.fallback_index = (start > 0) ? CLS_W'(start - 1) : '0;
        r.fallback_valid = (start > 0);
        return r;
    endfunction

    task automatic compare_field(string name, int unsigned exp_val, int unsigned got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
                     got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_map = '0;
            predicted_classes.delete();
        end else begin
            if (s_valid && s_ready)
                predicted_classes.push_back(
                    classify_request(s_req_type, s_request_size, s_list_index));
            if (m_valid && m_ready) begin
                if (predicted_classes.size() == 0) begin
                    $display("%0t: unexpected item, expected none actual class %0d",
                             $time, m_class_index);
                    mismatch_count++;
                end else begin
                    want = predicted_classes.pop_front();
                    compare_field("class_index", want.class_index, m_class_index);
                    compare_field("found", want.found, m_found);
                    compare_field("start_class", want.start_class, m_start_class);
                    compare_field("fallback_index", want.fallback_index, m_fallback_index);
                    compare_field("fallback_valid", want.fallback_valid, m_fallback_valid);
                end
            end
        end
        pending_count = predicted_classes.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the size class selector with random idling on both
// sides and a long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    import scfl_pkg::*;

    localparam int unsigned N_CLASSES  = 46;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned RESULTS_BEFORE_HOLD = 1000;
    localparam int unsigned HOLD_CYCLES         = 200;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [TYPE_W-1:0]   s_req_type     = REQ_FIND;
    logic [SIZE_W-1:0]   s_request_size = '0;
    logic [CLS_W-1:0]    s_list_index   = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [CLS_W-1:0]    m_class_index;
    logic                m_found;
    logic [CLS_W-1:0]    m_start_class;
    logic [CLS_W-1:0]    m_fallback_index;
    logic                m_fallback_valid;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 49;

    size_class_free_list_selector_top #(.NUM_LISTS(N_CLASSES)) dut (.*);

    size_class_free_list_selector_checker #(.NUM_LISTS(N_CLASSES)) checker_i (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        int unsigned taken;
        int unsigned hold_left;
        bit          held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                taken++;
            if (!held && taken >= RESULTS_BEFORE_HOLD) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(logic [TYPE_W-1:0] req, logic [SIZE_W-1:0] size,
                             logic [CLS_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_request_size <= size;
        s_list_index   <= idx;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        int unsigned k;
        logic [SIZE_W-1:0] base;
        case ($urandom_range(6))
            0: return $urandom_range(24);
            1: return $urandom_range(1024, 25);
            2: begin
                // exact class sizes and their neighbors
                case ($urandom_range(2))
                    0: base = 16 + 8 * $urandom_range(1);
                    1: base = 32 * $urandom_range(32, 1);
                    default: base = 32'd1 << $urandom_range(21, 11);
                endcase
                return base + $urandom_range(2) - 1;
            end
            3: begin
                k = $urandom_range(21, 11);
                return (32'd1 << (k - 1)) + 1 + $urandom_range((32'd1 << (k - 1)) - 1);
            end
            4: return MAX_BLOCK + $urandom_range(2) - 1;
            5: return $urandom;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic send_random_item();
        int unsigned pick;
        logic [TYPE_W-1:0] req;
        logic [CLS_W-1:0]  idx;
        pick = $urandom_range(99);
        if (pick < 40)
            req = REQ_FIND;
        else if (pick < 75)
            req = REQ_INSERT;
        else if (pick < 96)
            req = REQ_EMPTY;
        else
            req = REQ_UNUSED;
        // mostly real classes, sometimes out of range
        if ($urandom_range(99) < 90)
            idx = CLS_W'($urandom_range(N_CLASSES - 1));
        else
            idx = CLS_W'($urandom_range(63));
        send_item(req, random_size(), idx);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty map: nothing to find
        send_item(REQ_FIND, 32'd1, 6'd0);
        send_item(REQ_FIND, 32'hFFFF_FFFF, 6'd63);
        // class boundaries, tiny sizes and the catch-all
        send_item(REQ_INSERT, 32'd0, 6'd0);
        send_item(REQ_INSERT, 32'd16, 6'd0);
        send_item(REQ_INSERT, 32'd17, 6'd0);
        send_item(REQ_INSERT, 32'd24, 6'd0);
        send_item(REQ_INSERT, 32'd25, 6'd0);
        send_item(REQ_INSERT, 32'd1024, 6'd0);
        send_item(REQ_INSERT, 32'd1025, 6'd0);
        send_item(REQ_INSERT, 32'd2048, 6'd0);
        send_item(REQ_INSERT, 32'd2049, 6'd0);
        send_item(REQ_INSERT, MAX_BLOCK, 6'd0);
        send_item(REQ_INSERT, MAX_BLOCK + 32'd1, 6'd0);
        send_item(REQ_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_item(REQ_FIND, 32'd1, 6'd0);
        send_item(REQ_FIND, 32'd24, 6'd0);
        send_item(REQ_FIND, 32'd1000, 6'd0);
        send_item(REQ_FIND, 32'd2048, 6'd0);
        send_item(REQ_FIND, MAX_BLOCK, 6'd0);
        send_item(REQ_FIND, MAX_BLOCK + 32'd1, 6'd0);
        // empty reports, including indexes past the last class
        send_item(REQ_EMPTY, 32'd5, 6'd45);
        send_item(REQ_EMPTY, 32'd5, 6'd0);
        send_item(REQ_EMPTY, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_EMPTY, 32'd0, 6'd46);
        send_item(REQ_UNUSED, 32'd5000, 6'd7);
        send_item(REQ_FIND, 32'hFFFF_FFFF, 6'd0);

        repeat (450) send_random_item();
        send_idle_pct = 49;
        recv_idle_pct = 30;
        repeat (450) send_random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (425) send_random_item();
        s_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/scfl_pkg.sv
rtl/core/scfl_ctrl.sv
rtl/core/scfl_dp.sv
rtl/core/size_class_free_list_selector_top.sv
dv/size_class_free_list_selector_checker.sv
dv/testbench.sv
